FILE: hdl/motion_centroid_roi_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the moving-pixel centroid core
// Shared shorthand for clocked checks with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef MOTION_CENTROID_ROI_CORE_MACROS_SVH
`define MOTION_CENTROID_ROI_CORE_MACROS_SVH

// same-cycle implication
`define MCR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define MCR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: hdl/mcr_pkg.sv
// ---------------------------------------------------------------------------
// mcr_pkg
// Types and fixed constants of the moving-pixel centroid core.
// ---------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

   // field widths
   localparam int PIX_W   = 8;
   localparam int COORD_W = 11;
   localparam int SUM_W   = 33;
   localparam int CNT_W   = 23;
   localparam int OUT_W   = 12;
   localparam int LEN_W   = 10;
   localparam int SIZE_W  = 12;

   // signed width for window arithmetic
   localparam int CALC_W = 14;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // register port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // register reset values
   localparam logic [PIX_W-1:0]  THRESHOLD_RST = 8'd50;
   localparam logic [LEN_W-1:0]  HALF_SIZE_RST = 10'd30;
   localparam logic [SIZE_W-1:0] WIDTH_RST     = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RST    = 12'd480;

   // marker for "no centroid" and "no window"
   localparam logic signed [OUT_W-1:0] NONE_VAL = -12'sd1;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_HALF_SIZE = 2'd1,
      REG_WIDTH     = 2'd2,
      REG_HEIGHT    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0]  threshold;
      logic [LEN_W-1:0]  half_size;
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_LOAD,
      ST_DIV,
      ST_WIN1,
      ST_WIN2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic acc_en;
      logic load;
      logic div_step;
      logic win_first;
      logic win_second;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/mcr_csr.sv
// ---------------------------------------------------------------------------
// mcr_csr
// Configuration registers behind the APB-style port.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_csr
   import mcr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type sel;
   logic          wr_en;

   assign sel    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // decode write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_THRESHOLD: cfg_in.threshold    = pwdata[PIX_W-1:0];
            REG_HALF_SIZE: cfg_in.half_size    = pwdata[LEN_W-1:0];
            REG_WIDTH:     cfg_in.frame_width  = pwdata[SIZE_W-1:0];
            REG_HEIGHT:    cfg_in.frame_height = pwdata[SIZE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THRESHOLD_RST;
         cfg_ff.half_size    <= HALF_SIZE_RST;
         cfg_ff.frame_width  <= WIDTH_RST;
         cfg_ff.frame_height <= HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (sel)
         REG_THRESHOLD: prdata = DATA_W'(cfg_ff.threshold);
         REG_HALF_SIZE: prdata = DATA_W'(cfg_ff.half_size);
         REG_WIDTH:     prdata = DATA_W'(cfg_ff.frame_width);
         REG_HEIGHT:    prdata = DATA_W'(cfg_ff.frame_height);
         default:       prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/mcr_ctrl.sv
// ---------------------------------------------------------------------------
// mcr_ctrl
// Sequencer: accumulate pixels, then divide (skipped when no pixel moved), form the window and report.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_ctrl
   import mcr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       frame_end,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy,
   output logic            strobe
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_ACCUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      strobe   = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            busy       = 1'b0;
            cmd.acc_en = accept;
            if (accept && frame_end) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = status.count_zero ? ST_WIN1 : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_WIN1;
            end
         end
         ST_WIN1: begin
            cmd.win_first = 1'b1;
            state_in      = ST_WIN2;
         end
         ST_WIN2: begin
            cmd.win_second = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            strobe    = 1'b1;
            cmd.flush = 1'b1;
            state_in  = ST_ACCUM;
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/mcr_datapath.sv
// ---------------------------------------------------------------------------
// mcr_datapath
// Saturating sums, serial centroid divider and window clipping.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_datapath
   import mcr_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire cfg_type            cfg,
   input  wire logic [PIX_W-1:0]   pixel,
   input  wire logic [COORD_W-1:0] column,
   input  wire logic [COORD_W-1:0] row,
   output status_type              status,
   output logic signed [OUT_W-1:0] centroid_x,
   output logic signed [OUT_W-1:0] centroid_y,
   output logic [SUM_W-1:0]        column_sum,
   output logic [SUM_W-1:0]        row_sum,
   output logic [CNT_W-1:0]        moving_count,
   output logic signed [OUT_W-1:0] window_x,
   output logic signed [OUT_W-1:0] window_y,
   output logic signed [OUT_W-1:0] window_w,
   output logic signed [OUT_W-1:0] window_h
);

   // accumulators
   logic [SUM_W-1:0] acc_col_ff, acc_col_in;
   logic [SUM_W-1:0] acc_row_ff, acc_row_in;
   logic [CNT_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [SUM_W:0]   col_sum, row_sum_ext;
   logic             hit;

   // divider
   logic [SUM_W-1:0]     dvd_x_ff, dvd_x_in;
   logic [SUM_W-1:0]     dvd_y_ff, dvd_y_in;
   logic [CNT_W-1:0]     rem_x_ff, rem_x_in;
   logic [CNT_W-1:0]     rem_y_ff, rem_y_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CNT_W:0]       sh_x, sh_y, df_x, df_y;

   // window
   logic signed [OUT_W-1:0]  cen_x_ff, cen_x_in, cen_y_ff, cen_y_in;
   logic signed [OUT_W-1:0]  win_x_ff, win_x_in, win_y_ff, win_y_in;
   logic signed [OUT_W-1:0]  win_w_ff, win_w_in, win_h_ff, win_h_in;
   logic                     win_on_ff, win_on_in;
   logic signed [CALC_W-1:0] len_s, len2_s, dx, dy, cx_left, cy_top;
   logic signed [CALC_W-1:0] wx_s, wy_s, end_x, end_y, cols_s, rows_s;
   logic signed [CALC_W-1:0] rest_x, rest_y, ww_s, wh_s;
   logic [SIZE_W-1:0]        cols, rows;

   // accumulate moving pixels, saturating at all ones
   assign hit         = pixel > cfg.threshold;
   assign col_sum     = {1'b0, acc_col_ff} + (SUM_W+1)'(column);
   assign row_sum_ext = {1'b0, acc_row_ff} + (SUM_W+1)'(row);

   always_comb begin
      acc_col_in = acc_col_ff;
      acc_row_in = acc_row_ff;
      acc_cnt_in = acc_cnt_ff;
      if (cmd.flush) begin
         acc_col_in = '0;
         acc_row_in = '0;
         acc_cnt_in = '0;
      end else if (cmd.acc_en && hit) begin
         acc_col_in = col_sum[SUM_W] ? '1 : col_sum[SUM_W-1:0];
         acc_row_in = row_sum_ext[SUM_W] ? '1 : row_sum_ext[SUM_W-1:0];
         acc_cnt_in = (acc_cnt_ff == '1) ? acc_cnt_ff : acc_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_col_ff <= '0;
         acc_row_ff <= '0;
         acc_cnt_ff <= '0;
      end else begin
         acc_col_ff <= acc_col_in;
         acc_row_ff <= acc_row_in;
         acc_cnt_ff <= acc_cnt_in;
      end
   end

   // restoring division, one quotient bit per step for both axes
   assign sh_x = {rem_x_ff, dvd_x_ff[SUM_W-1]};
   assign sh_y = {rem_y_ff, dvd_y_ff[SUM_W-1]};
   assign df_x = sh_x - {1'b0, acc_cnt_ff};
   assign df_y = sh_y - {1'b0, acc_cnt_ff};

   always_comb begin
      dvd_x_in   = dvd_x_ff;
      dvd_y_in   = dvd_y_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.load) begin
         dvd_x_in   = acc_col_ff;
         dvd_y_in   = acc_row_ff;
         rem_x_in   = '0;
         rem_y_in   = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         if (sh_x >= {1'b0, acc_cnt_ff}) begin
            rem_x_in = df_x[CNT_W-1:0];
            dvd_x_in = {dvd_x_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_x_in = sh_x[CNT_W-1:0];
            dvd_x_in = {dvd_x_ff[SUM_W-2:0], 1'b0};
         end
         if (sh_y >= {1'b0, acc_cnt_ff}) begin
            rem_y_in = df_y[CNT_W-1:0];
            dvd_y_in = {dvd_y_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_y_in = sh_y[CNT_W-1:0];
            dvd_y_in = {dvd_y_ff[SUM_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_x_ff <= dvd_x_in;
      dvd_y_ff <= dvd_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign status.count_zero = (acc_cnt_ff == '0);
   assign status.div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // frame size limited to the supported maximum
   assign cols = (32'(cfg.frame_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : cfg.frame_width;
   assign rows = (32'(cfg.frame_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT)
                                                      : cfg.frame_height;

   // first window step: centroid and clipped top-left corner
   assign len_s   = $signed({{(CALC_W-LEN_W){1'b0}}, cfg.half_size});
   assign len2_s  = len_s <<< 1;
   assign cx_left = $signed({{(CALC_W-COORD_W){1'b0}}, dvd_x_ff[COORD_W-1:0]});
   assign cy_top  = $signed({{(CALC_W-COORD_W){1'b0}}, dvd_y_ff[COORD_W-1:0]});
   assign dx      = cx_left - len_s;
   assign dy      = cy_top - len_s;

   // second window step: width and height cut at the frame edge
   assign wx_s   = $signed({{(CALC_W-COORD_W){1'b0}}, win_x_ff[COORD_W-1:0]});
   assign wy_s   = $signed({{(CALC_W-COORD_W){1'b0}}, win_y_ff[COORD_W-1:0]});
   assign cols_s = $signed({{(CALC_W-SIZE_W){1'b0}}, cols});
   assign rows_s = $signed({{(CALC_W-SIZE_W){1'b0}}, rows});
   assign end_x  = wx_s + len2_s;
   assign end_y  = wy_s + len2_s;
   assign rest_x = cols_s - wx_s;
   assign rest_y = rows_s - wy_s;
   assign ww_s   = (end_x > cols_s) ? ((rest_x < 0) ? '0 : rest_x) : len2_s;
   assign wh_s   = (end_y > rows_s) ? ((rest_y < 0) ? '0 : rest_y) : len2_s;

   always_comb begin
      cen_x_in  = cen_x_ff;
      cen_y_in  = cen_y_ff;
      win_x_in  = win_x_ff;
      win_y_in  = win_y_ff;
      win_w_in  = win_w_ff;
      win_h_in  = win_h_ff;
      win_on_in = win_on_ff;
      if (cmd.win_first) begin
         if (status.count_zero) begin
            cen_x_in = NONE_VAL;
            cen_y_in = NONE_VAL;
         end else begin
            cen_x_in = $signed({1'b0, dvd_x_ff[COORD_W-1:0]});
            cen_y_in = $signed({1'b0, dvd_y_ff[COORD_W-1:0]});
         end
         win_on_in = !status.count_zero && (dvd_x_ff[COORD_W-1:0] != '0);
         win_x_in  = (dx < 0) ? '0 : dx[OUT_W-1:0];
         win_y_in  = (dy < 0) ? '0 : dy[OUT_W-1:0];
      end else if (cmd.win_second) begin
         if (win_on_ff) begin
            win_w_in = ww_s[OUT_W-1:0];
            win_h_in = wh_s[OUT_W-1:0];
         end else begin
            win_x_in = NONE_VAL;
            win_y_in = NONE_VAL;
            win_w_in = NONE_VAL;
            win_h_in = NONE_VAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      cen_x_ff  <= cen_x_in;
      cen_y_ff  <= cen_y_in;
      win_x_ff  <= win_x_in;
      win_y_ff  <= win_y_in;
      win_w_ff  <= win_w_in;
      win_h_ff  <= win_h_in;
      win_on_ff <= win_on_in;
   end

   assign centroid_x   = cen_x_ff;
   assign centroid_y   = cen_y_ff;
   assign column_sum   = acc_col_ff;
   assign row_sum      = acc_row_ff;
   assign moving_count = acc_cnt_ff;
   assign window_x     = win_x_ff;
   assign window_y     = win_y_ff;
   assign window_w     = win_w_ff;
   assign window_h     = win_h_ff;

endmodule

`default_nettype wire

FILE: hdl/motion_centroid_roi_core.sv
// Takes one pixel per cycle while busy is low; pixels between frame ends never stall.
// The beat carrying frame_end raises busy; the result strobe follows the load state, the
// 33-step restoring divider and two window steps; the divider is skipped when no pixel moved.
// busy falls the cycle after the strobe.
// Synchronous reset loads register defaults, clears the sums and returns to idle.
// The result is shown for one cycle only; the receiver cannot stall it.
// ---------------------------------------------------------------------------
// motion_centroid_roi_core
// Centroid of thresholded difference pixels with a clipped square window.
// ---------------------------------------------------------------------------
`default_nettype none

`include "motion_centroid_roi_core_macros.svh"

module motion_centroid_roi_core
   import mcr_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [PIX_W-1:0]   req_pixel,
   input  wire logic [COORD_W-1:0] req_column,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic               req_frame_end,
   // result channel
   output logic                    rsp_strobe,
   output logic signed [OUT_W-1:0] rsp_centroid_x,
   output logic signed [OUT_W-1:0] rsp_centroid_y,
   output logic [SUM_W-1:0]        rsp_column_sum,
   output logic [SUM_W-1:0]        rsp_row_sum,
   output logic [CNT_W-1:0]        rsp_moving_count,
   output logic signed [OUT_W-1:0] rsp_window_x,
   output logic signed [OUT_W-1:0] rsp_window_y,
   output logic signed [OUT_W-1:0] rsp_window_w,
   output logic signed [OUT_W-1:0] rsp_window_h,
   // configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic      [DATA_W-1:0]  prdata,
   output logic                    pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   mcr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .frame_end (req_frame_end),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .strobe    (rsp_strobe)
   );

   mcr_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .pixel        (req_pixel),
      .column       (req_column),
      .row          (req_row),
      .status       (status),
      .centroid_x   (rsp_centroid_x),
      .centroid_y   (rsp_centroid_y),
      .column_sum   (rsp_column_sum),
      .row_sum      (rsp_row_sum),
      .moving_count (rsp_moving_count),
      .window_x     (rsp_window_x),
      .window_y     (rsp_window_y),
      .window_w     (rsp_window_w),
      .window_h     (rsp_window_h)
   );

   // frame end beat locks out further pixels
   `MCR_ASSERT_NXT(a_end_sets_busy, clock, reset, start && !busy && req_frame_end, busy)
   // sums clear once the result beat is taken
   `MCR_ASSERT_NXT(a_flush_after_beat, clock, reset, rsp_strobe, rsp_moving_count == '0)
   // no moving pixel gives no centroid
   `MCR_ASSERT_IMP(a_empty_no_centroid, clock, reset, rsp_strobe && rsp_moving_count == '0,
      rsp_centroid_x == NONE_VAL && rsp_centroid_y == NONE_VAL)
   // window only when the centroid column is above zero
   `MCR_ASSERT_IMP(a_window_gated, clock, reset, rsp_strobe && rsp_centroid_x <= 12'sd0,
      rsp_window_x == NONE_VAL && rsp_window_w == NONE_VAL)

endmodule

`default_nettype wire

FILE: dv/tb_motion_centroid_roi_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_motion_centroid_roi_core
// Checks the moving-pixel centroid core against an in-bench frame predictor.
// Pixel beats come from a queue through a start/busy driver with random gaps.
// Each frame-end result is compared field by field with the predicted centroid,
// sums, count and window. Registers are rewritten between phases while the
// core is idle, covering their extremes. Some phases leave a frame open across
// the register change.
// ---------------------------------------------------------------------------

module tb_motion_centroid_roi_core
   import mcr_pkg::*;
();

   localparam int MAX_COLS     = 2048;
   localparam int MAX_ROWS     = 2048;
   localparam int RANDOM_BEATS = 1000;
   localparam int STALL_LIMIT  = 2000;
   localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;
   localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;

   typedef struct {
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_end;
   } pixel_beat_type;

   typedef struct {
      logic signed [OUT_W-1:0] centroid_x;
      logic signed [OUT_W-1:0] centroid_y;
      logic [SUM_W-1:0]        column_sum;
      logic [SUM_W-1:0]        row_sum;
      logic [CNT_W-1:0]        moving_count;
      logic signed [OUT_W-1:0] window_x;
      logic signed [OUT_W-1:0] window_y;
      logic signed [OUT_W-1:0] window_w;
      logic signed [OUT_W-1:0] window_h;
   } frame_result_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [PIX_W-1:0]        req_pixel = '0;
   logic [COORD_W-1:0]      req_column = '0;
   logic [COORD_W-1:0]      req_row = '0;
   logic                    req_frame_end = 1'b0;
   logic                    rsp_strobe;
   logic signed [OUT_W-1:0] rsp_centroid_x;
   logic signed [OUT_W-1:0] rsp_centroid_y;
   logic [SUM_W-1:0]        rsp_column_sum;
   logic [SUM_W-1:0]        rsp_row_sum;
   logic [CNT_W-1:0]        rsp_moving_count;
   logic signed [OUT_W-1:0] rsp_window_x;
   logic signed [OUT_W-1:0] rsp_window_y;
   logic signed [OUT_W-1:0] rsp_window_w;
   logic signed [OUT_W-1:0] rsp_window_h;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [ADDR_W-1:0]       paddr = '0;
   logic [DATA_W-1:0]       pwdata = '0;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   // predictor state: register shadow and frame accumulators
   cfg_type          shadow_cfg;
   longint unsigned  sum_col;
   longint unsigned  sum_row;
   longint unsigned  moving_pixels;

   pixel_beat_type   pending_pixels[$];
   frame_result_type expected_frames[$];

   int idle_pct = 0;
   int gap_left = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int beats_queued = 0;

   motion_centroid_roi_core #(
      .MAX_WIDTH  (MAX_COLS),
      .MAX_HEIGHT (MAX_ROWS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel        (req_pixel),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_frame_end    (req_frame_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_centroid_x   (rsp_centroid_x),
      .rsp_centroid_y   (rsp_centroid_y),
      .rsp_column_sum   (rsp_column_sum),
      .rsp_row_sum      (rsp_row_sum),
      .rsp_moving_count (rsp_moving_count),
      .rsp_window_x     (rsp_window_x),
      .rsp_window_y     (rsp_window_y),
      .rsp_window_w     (rsp_window_w),
      .rsp_window_h     (rsp_window_h),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned clamp_add(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned lim);
      return (a + b > lim) ? lim : a + b;
   endfunction

   // accumulate one accepted pixel; on frame end predict the result and clear
   function automatic void accumulate_pixel(input pixel_beat_type b);
      frame_result_type res;
      longint cx, cy, wx, wy, ww, wh, len, cols, rows;
      if (b.pixel > shadow_cfg.threshold) begin
         sum_col       = clamp_add(sum_col, b.column, SUM_MAX);
         sum_row       = clamp_add(sum_row, b.row, SUM_MAX);
         moving_pixels = clamp_add(moving_pixels, 1, CNT_MAX);
      end
      if (!b.frame_end) return;

      if (moving_pixels != 0) begin
         cx = longint'(sum_col / moving_pixels);
         cy = longint'(sum_row / moving_pixels);
      end else begin
         cx = -1;
         cy = -1;
      end

      // window only when the centroid column is above zero
      if (cx > 0) begin
         len  = shadow_cfg.half_size;
         cols = shadow_cfg.frame_width;
         rows = shadow_cfg.frame_height;
         if (cols > MAX_COLS) cols = MAX_COLS;
         if (rows > MAX_ROWS) rows = MAX_ROWS;
         wx = cx - len;
         wy = cy - len;
         ww = 2 * len;
         wh = 2 * len;
         if (wx < 0) wx = 0;
         if (wy < 0) wy = 0;
         if (wx + ww > cols) ww = cols - wx;
         if (wy + wh > rows) wh = rows - wy;
         if (ww < 0) ww = 0;
         if (wh < 0) wh = 0;
      end else begin
         wx = -1;
         wy = -1;
         ww = -1;
         wh = -1;
      end

      res.centroid_x   = OUT_W'(cx);
      res.centroid_y   = OUT_W'(cy);
      res.column_sum   = SUM_W'(sum_col);
      res.row_sum      = SUM_W'(sum_row);
      res.moving_count = CNT_W'(moving_pixels);
      res.window_x     = OUT_W'(wx);
      res.window_y     = OUT_W'(wy);
      res.window_w     = OUT_W'(ww);
      res.window_h     = OUT_W'(wh);
      expected_frames.push_back(res);
      sum_col       = 0;
      sum_row       = 0;
      moving_pixels = 0;
   endfunction

   // driver: hold a beat while busy, insert random gaps, else load the next one
   always @(posedge clock) begin
      pixel_beat_type beat;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            beat.pixel     = req_pixel;
            beat.column    = req_column;
            beat.row       = req_row;
            beat.frame_end = req_frame_end;
            accumulate_pixel(beat);
         end
         if (start && busy) begin
            // hold the current beat
         end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            gap_left <= $urandom_range(18, 0);
         end else if (pending_pixels.size() != 0) begin
            beat = pending_pixels.pop_front();
            req_pixel     <= beat.pixel;
            req_column    <= beat.column;
            req_row       <= beat.row;
            req_frame_end <= beat.frame_end;
            start         <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // monitor: compare each strobed result with the oldest predicted frame
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_frames.size() == 0) begin
            $error("result strobe with no frame pending");
            mismatches++;
         end else begin
            want = expected_frames.pop_front();
            check_field("centroid_x", want.centroid_x, rsp_centroid_x);
            check_field("centroid_y", want.centroid_y, rsp_centroid_y);
            check_field("column_sum", want.column_sum, rsp_column_sum);
            check_field("row_sum", want.row_sum, rsp_row_sum);
            check_field("moving_count", want.moving_count, rsp_moving_count);
            check_field("window_x", want.window_x, rsp_window_x);
            check_field("window_y", want.window_y, rsp_window_y);
            check_field("window_w", want.window_w, rsp_window_w);
            check_field("window_h", want.window_h, rsp_window_h);
         end
      end
   end

   // watchdog: end the run when no beat, result or register write moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[motion_centroid_roi_core] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic void queue_pixel(input int pix, input int col, input int row,
                                       input bit last);
      pixel_beat_type beat;
      beat.pixel     = PIX_W'(pix);
      beat.column    = COORD_W'(col);
      beat.row       = COORD_W'(row);
      beat.frame_end = last;
      pending_pixels.push_back(beat);
      beats_queued++;
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : (v > 2047) ? 2047 : v;
   endfunction

   // one frame of random pixels; the shape picks how the coordinates cluster
   task automatic queue_random_frame(input bit close_frame);
      int n, shape, cx, cy, spread, c, r, k, pix, thr;
      n      = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      shape  = $urandom_range(3);
      cx     = $urandom_range(2047);
      cy     = $urandom_range(2047);
      spread = $urandom_range(64);
      thr    = shadow_cfg.threshold;
      for (k = 0; k < n; k++) begin
         case (shape)
            0: begin
               c = $urandom_range(2047);
               r = $urandom_range(2047);
            end
            1: begin
               c = clamp_coord(cx + $urandom_range(2 * spread) - spread);
               r = clamp_coord(cy + $urandom_range(2 * spread) - spread);
            end
            2: begin
               // hug the right and bottom frame edges
               c = clamp_coord(int'(shadow_cfg.frame_width) + $urandom_range(8) - 4);
               r = clamp_coord(int'(shadow_cfg.frame_height) + $urandom_range(8) - 4);
            end
            default: begin
               // centroid column near zero
               c = $urandom_range(1);
               r = $urandom_range(2047);
            end
         endcase
         case ($urandom_range(3))
            0: pix = $urandom_range(255);
            1: pix = thr;
            2: pix = (thr == 255) ? 255 : thr + 1;
            default: pix = $urandom_range(1) ? 255 : 0;
         endcase
         queue_pixel(pix, c, r, close_frame && k == n - 1);
      end
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_THRESHOLD: shadow_cfg.threshold    = value[PIX_W-1:0];
         REG_HALF_SIZE: shadow_cfg.half_size    = value[LEN_W-1:0];
         REG_WIDTH:     shadow_cfg.frame_width  = value[SIZE_W-1:0];
         default:       shadow_cfg.frame_height = value[SIZE_W-1:0];
      endcase
   endtask

   task automatic write_all(input int thr, input int half, input int wid, input int hgt);
      csr_write(REG_THRESHOLD, DATA_W'(thr));
      csr_write(REG_HALF_SIZE, DATA_W'(half));
      csr_write(REG_WIDTH, DATA_W'(wid));
      csr_write(REG_HEIGHT, DATA_W'(hgt));
   endtask

   // wait until every beat is taken and every result is in, then let the core settle
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || start || busy || expected_frames.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int pick_size();
      case ($urandom_range(4))
         0: return 0;
         1: return 1;
         2: return 2048;
         3: return 4095;
         default: return $urandom_range(2048, 1);
      endcase
   endfunction

   initial begin
      int phase, budget, phase_base, thr, half;
      shadow_cfg    = '{THRESHOLD_RST, HALF_SIZE_RST, WIDTH_RST, HEIGHT_RST};
      sum_col       = 0;
      sum_row       = 0;
      moving_pixels = 0;
      idle_pct      = 15;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed frames under the reset register values
      @(negedge clock);
      queue_pixel(0, 0, 0, 1);            // no moving pixel
      queue_pixel(51, 2047, 2047, 1);     // pixel outside the frame
      queue_pixel(50, 5, 5, 0);           // at threshold, not moving
      queue_pixel(255, 0, 100, 1);        // centroid column zero
      queue_pixel(255, 100, 0, 1);        // centroid row zero, window still formed
      queue_pixel(200, 10, 20, 0);
      queue_pixel(200, 11, 21, 1);        // truncated mean
      queue_pixel(51, 320, 240, 1);       // window inside the frame
      wait_drained();

      // lowest registers, zero frame size
      write_all(0, 0, 0, 0);
      @(negedge clock);
      queue_pixel(1, 5, 5, 1);
      queue_pixel(0, 7, 9, 1);
      wait_drained();

      // highest threshold and half size, frame width above the maximum, height at it
      write_all(255, 1023, 4095, 2048);
      @(negedge clock);
      queue_pixel(255, 1500, 1000, 1);
      wait_drained();
      csr_write(REG_THRESHOLD, 254);
      @(negedge clock);
      queue_pixel(255, 1500, 1000, 1);
      queue_pixel(255, 2047, 0, 0);
      queue_pixel(255, 0, 2047, 1);
      queue_pixel(255, 1024, 1024, 1);

      // random phases, each with its own register setting and idle rate
      beats_queued = 0;
      phase = 0;
      while (beats_queued < RANDOM_BEATS) begin
         wait_drained();
         case (phase)
            0: write_all(0, 1023, 2048, 2048);
            1: write_all(255, 0, 1, 1);
            default: begin
               thr  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 255 : 0)
                                               : $urandom_range(255);
               half = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 1023 : 0)
                                               : $urandom_range(1023);
               write_all(thr, half, pick_size(), pick_size());
            end
         endcase
         @(negedge clock);
         if (beats_queued > RANDOM_BEATS * 85 / 100) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(3))
               0: idle_pct = 0;
               1: idle_pct = 5;
               2: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         budget     = $urandom_range(160, 60);
         phase_base = beats_queued;
         while (beats_queued - phase_base < budget)
            queue_random_frame(1'b1);
         // leave a frame open across the next register change
         if ($urandom_range(2) == 0)
            queue_random_frame(1'b0);
         phase++;
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("[motion_centroid_roi_core] OK");
      else
         $display("[motion_centroid_roi_core] ERROR");
      $finish;
   end

endmodule
